// File: design/cetd_pkg.sv
// Package for the cyclic error-trapping decoder: sizes, codes and the
// command and status structs shared by the controller and the datapath.
// Depends on nothing.
`default_nettype none

package cetd_pkg;

	// Sizing of the code.
	localparam int MAX_N      = 32;
	localparam int MAX_PARITY = 16;

	// Fixed field widths.
	localparam int WORD_W  = 32;
	localparam int GEN_W   = 17;
	localparam int NLEN_W  = 6;
	localparam int KLEN_W  = 5;
	localparam int LIMIT_W = 5;
	localparam int SHIFT_W = 5;
	localparam int SYN_W   = 16;
	localparam int CIDX_W  = 2;

	// Effective limits: the word and syndrome fields cap the sizing constants.
	localparam int N_EFF_MAX = (MAX_N < WORD_W) ? MAX_N : WORD_W;
	localparam int PAR_LIM   = (MAX_PARITY < SYN_W) ? MAX_PARITY : SYN_W;
	localparam int CNT_W     = $clog2(N_EFF_MAX);

	// Register reset values.
	localparam logic [GEN_W-1:0]   GEN_RESET   = GEN_W'(1533);
	localparam logic [NLEN_W-1:0]  NLEN_RESET  = NLEN_W'(18);
	localparam logic [KLEN_W-1:0]  KLEN_RESET  = KLEN_W'(8);
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(2);

	typedef enum logic [CIDX_W-1:0] {
		CFG_GEN_POLY      = 2'd0,
		CFG_CODE_LENGTH   = 2'd1,
		CFG_INFO_LENGTH   = 2'd2,
		CFG_CORRECT_LIMIT = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		ST_VALID         = 2'd0,
		ST_CORRECTED     = 2'd1,
		ST_UNCORRECTABLE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SYND,
		S_EVAL,
		S_TRIAL,
		S_FIX,
		S_FINISH
	} ctrl_state_t;

	// Controller to datapath.
	typedef struct packed {
		logic start;
		logic synd_step;
		logic eval;
		logic trial_step;
		logic fix;
		logic load_out;
	} ctrl_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic geom_ok;
		logic synd_last;
		logic syn_zero;
		logic trapped;
		logic rot_last;
	} dp_status_t;

endpackage

`default_nettype wire

// File: design/cetd_ctrl.sv
// Sequencer of the error-trapping decoder: input and output handshakes and
// the phase state machine. Uses cetd_pkg.
`default_nettype none

module cetd_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	input  wire cetd_pkg::dp_status_t dp_status,
	output cetd_pkg::ctrl_cmd_t       cmd
);
	import cetd_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;
	logic        out_valid_q;
	logic        out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_nxt = S_SYND;
			end
			S_SYND: begin
				if (!dp_status.geom_ok) state_nxt = S_FINISH;
				else if (dp_status.synd_last) state_nxt = S_EVAL;
			end
			S_EVAL: begin
				state_nxt = dp_status.syn_zero ? S_FINISH : S_TRIAL;
			end
			S_TRIAL: begin
				if (dp_status.trapped) state_nxt = S_FIX;
				else if (dp_status.rot_last) state_nxt = S_FINISH;
			end
			S_FIX: begin
				state_nxt = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE:   cmd.start      = in_valid;
			S_SYND:   cmd.synd_step  = dp_status.geom_ok;
			S_EVAL:   cmd.eval       = 1'b1;
			S_TRIAL:  cmd.trial_step = !dp_status.trapped && !dp_status.rot_last;
			S_FIX:    cmd.fix        = 1'b1;
			S_FINISH: cmd.load_out   = out_free;
			default:  cmd            = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// File: design/cetd_datapath.sv
// Datapath of the error-trapping decoder: syndrome divider, rotation and
// trapping check, correction and the result registers. Uses cetd_pkg.
`default_nettype none

module cetd_datapath (
	input  wire logic                                 clk,
	input  wire cetd_pkg::ctrl_cmd_t                  cmd,
	output cetd_pkg::dp_status_t                      dp_status,
	input  wire logic [cetd_pkg::WORD_W-1:0]          received_word,
	input  wire logic [cetd_pkg::GEN_W-1:0]           gen_poly_q,
	input  wire logic [cetd_pkg::NLEN_W-1:0]          code_length_q,
	input  wire logic [cetd_pkg::KLEN_W-1:0]          info_length_q,
	input  wire logic [cetd_pkg::LIMIT_W-1:0]         correct_limit_q,
	output logic [cetd_pkg::WORD_W-1:0]               corrected_word,
	output logic [1:0]                                status,
	output logic [cetd_pkg::SHIFT_W-1:0]              shift_count,
	output logic [cetd_pkg::SYN_W-1:0]                syndrome
);
	import cetd_pkg::*;

	// One step of multiply-by-x modulo g: shift in a bit, reduce once.
	function automatic logic [SYN_W-1:0] mulx(input logic [SYN_W-1:0] s, input logic b,
			input logic [4:0] p, input logic [GEN_W-1:0] g);
		logic [GEN_W-1:0] t;
		t = {s, b};
		if (t[p]) t = t ^ g;
		return t[SYN_W-1:0];
	endfunction

	function automatic logic [LIMIT_W:0] weight(input logic [SYN_W-1:0] s);
		logic [LIMIT_W:0] c;
		c = '0;
		for (int i = 0; i < SYN_W; i++) c = c + (LIMIT_W+1)'(s[i]);
		return c;
	endfunction

	logic [NLEN_W-1:0] n_eff;
	logic [NLEN_W-1:0] p_full;
	logic [4:0]        p;
	logic [63:0]       mask64;
	logic [WORD_W-1:0] mask;
	logic              geom_ok;
	logic [CNT_W-1:0]  top_idx;

	// Working registers.
	logic [WORD_W-1:0] w_q;
	logic [SYN_W-1:0]  s_q;
	logic [SYN_W-1:0]  h_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  r_q;

	// Result registers of the item in flight, and the output register.
	logic [WORD_W-1:0] res_word_q;
	status_t           res_status_q;
	logic [SHIFT_W-1:0] res_shift_q;
	logic [SYN_W-1:0]  res_syn_q;
	logic [WORD_W-1:0] out_word_q;
	status_t           out_status_q;
	logic [SHIFT_W-1:0] out_shift_q;
	logic [SYN_W-1:0]  out_syn_q;

	logic [WORD_W-1:0] rot1;
	logic [SYN_W-1:0]  s_next;
	logic [WORD_W-1:0] fixed;
	logic [WORD_W-1:0] rotr_lo;
	logic [63:0]       rotr_hi;
	logic [NLEN_W-1:0] back_amt;

	always_comb begin
		n_eff   = (code_length_q > NLEN_W'(N_EFF_MAX)) ? NLEN_W'(N_EFF_MAX) : code_length_q;
		p_full  = n_eff - NLEN_W'(info_length_q);
		p       = p_full[4:0];
		mask64  = (64'd1 << n_eff) - 64'd1;
		mask    = mask64[WORD_W-1:0];
		geom_ok = (n_eff >= NLEN_W'(2)) && (info_length_q != '0) &&
			(NLEN_W'(info_length_q) < n_eff) && (p_full <= NLEN_W'(PAR_LIM)) &&
			((gen_poly_q >> p_full) == GEN_W'(1));
		top_idx = CNT_W'(n_eff - NLEN_W'(1));
	end

	// Rotation by one place within n bits; the bit leaving the top feeds
	// the syndrome update through x^n + 1 mod g.
	always_comb begin
		rot1   = ((w_q << 1) | WORD_W'(w_q[top_idx])) & mask;
		s_next = mulx(s_q, 1'b0, p, gen_poly_q) ^ (w_q[top_idx] ? (h_q ^ SYN_W'(1)) : '0);
	end

	// Correction and rotation back by r within n bits.
	always_comb begin
		fixed    = w_q ^ WORD_W'(s_q);
		back_amt = n_eff - NLEN_W'(r_q);
		rotr_lo  = fixed >> r_q;
		rotr_hi  = 64'(fixed) << back_amt;
	end

	assign dp_status.geom_ok   = geom_ok;
	assign dp_status.synd_last = (cnt_q == '0);
	assign dp_status.syn_zero  = (s_q == '0);
	assign dp_status.trapped   = (weight(s_q) <= (LIMIT_W+1)'(correct_limit_q));
	assign dp_status.rot_last  = (r_q == top_idx);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			w_q          <= received_word & mask;
			s_q          <= '0;
			h_q          <= SYN_W'(1);
			cnt_q        <= top_idx;
			r_q          <= '0;
			res_word_q   <= received_word & mask;
			res_status_q <= ST_UNCORRECTABLE;
			res_shift_q  <= '0;
			res_syn_q    <= '0;
		end
		if (cmd.synd_step) begin
			s_q   <= mulx(s_q, w_q[cnt_q], p, gen_poly_q);
			h_q   <= mulx(h_q, 1'b0, p, gen_poly_q);
			cnt_q <= cnt_q - CNT_W'(1);
		end
		if (cmd.eval) begin
			res_syn_q <= s_q;
			if (s_q == '0) res_status_q <= ST_VALID;
		end
		if (cmd.trial_step) begin
			w_q <= rot1;
			s_q <= s_next;
			r_q <= r_q + CNT_W'(1);
		end
		if (cmd.fix) begin
			res_word_q   <= (rotr_lo | rotr_hi[WORD_W-1:0]) & mask;
			res_status_q <= ST_CORRECTED;
			res_shift_q  <= SHIFT_W'(r_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_word_q   <= res_word_q;
			out_status_q <= res_status_q;
			out_shift_q  <= res_shift_q;
			out_syn_q    <= res_syn_q;
		end
	end

	assign corrected_word = out_word_q;
	assign status         = out_status_q;
	assign shift_count    = out_shift_q;
	assign syndrome       = out_syn_q;

endmodule

`default_nettype wire

// File: design/cyclic_error_trapping_decoder_core.sv
// Top level of the cyclic error-trapping decoder: configuration registers
// and the controller and datapath instances. Uses cetd_pkg, cetd_ctrl and
// cetd_datapath.
`default_nettype none

// Channel   Direction  Handshake             Payload
// in        in         in_valid / in_stall   received_word
// out       out        out_valid / out_stall corrected_word, status, shift_count, syndrome
// cfg       in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// An item passes through an accept step, the syndrome phase over its n bits, an
// evaluation step, up to n rotation trials, a correction step and the load into the
// output register, paced by the bit-serial divider and the one-place rotation.
// A valid codeword skips the rotation trials; a bad geometry leaves the syndrome
// phase before any division step and goes straight to the output load.
// Reset clears the controller and loads the register reset values.
// A stalled output holds its item; the next item may be accepted meanwhile and
// waits in its last phase until the output register is free.

module cyclic_error_trapping_decoder_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [cetd_pkg::WORD_W-1:0]    received_word,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [cetd_pkg::WORD_W-1:0]         corrected_word,
	output logic [1:0]                          status,
	output logic [cetd_pkg::SHIFT_W-1:0]        shift_count,
	output logic [cetd_pkg::SYN_W-1:0]          syndrome,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [cetd_pkg::CIDX_W-1:0]    cfg_index,
	input  wire logic [cetd_pkg::GEN_W-1:0]     cfg_data
);
	import cetd_pkg::*;

	logic [GEN_W-1:0]   gen_poly_q;
	logic [NLEN_W-1:0]  code_length_q;
	logic [KLEN_W-1:0]  info_length_q;
	logic [LIMIT_W-1:0] correct_limit_q;

	ctrl_cmd_t  cmd;
	dp_status_t dp_status;

	// Writes must arrive only while the decoder is idle, unenforced; cfg_ready stays high.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_poly_q      <= GEN_RESET;
			code_length_q   <= NLEN_RESET;
			info_length_q   <= KLEN_RESET;
			correct_limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index_t'(cfg_index))
				CFG_GEN_POLY:      gen_poly_q      <= cfg_data;
				CFG_CODE_LENGTH:   code_length_q   <= cfg_data[NLEN_W-1:0];
				CFG_INFO_LENGTH:   info_length_q   <= cfg_data[KLEN_W-1:0];
				CFG_CORRECT_LIMIT: correct_limit_q <= cfg_data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The controller sequences the phases and owns both handshakes.
	cetd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dp_status (dp_status),
		.cmd       (cmd)
	);

	// The datapath divides, rotates, traps and corrects, and holds the result.
	// It carries payload only, so it needs no reset.
	cetd_datapath u_datapath (
		.clk             (clk),
		.cmd             (cmd),
		.dp_status       (dp_status),
		.received_word   (received_word),
		.gen_poly_q      (gen_poly_q),
		.code_length_q   (code_length_q),
		.info_length_q   (info_length_q),
		.correct_limit_q (correct_limit_q),
		.corrected_word  (corrected_word),
		.status          (status),
		.shift_count     (shift_count),
		.syndrome        (syndrome)
	);

endmodule

`default_nettype wire

// File: tb/decode_checker.sv
// Checker for the cyclic error-trapping decoder. It follows the input, output and
// register write channels, predicts every decode from its own copy of the registers,
// and compares each result against the oldest prediction. Depends on cetd_pkg.

module decode_checker (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire logic                         in_stall,
	input  wire logic [cetd_pkg::WORD_W-1:0]  received_word,
	input  wire logic                         out_valid,
	input  wire logic                         out_stall,
	input  wire logic [cetd_pkg::WORD_W-1:0]  corrected_word,
	input  wire logic [1:0]                   status,
	input  wire logic [cetd_pkg::SHIFT_W-1:0] shift_count,
	input  wire logic [cetd_pkg::SYN_W-1:0]   syndrome,
	input  wire logic                         cfg_valid,
	input  wire logic                         cfg_ready,
	input  wire logic [cetd_pkg::CIDX_W-1:0]  cfg_index,
	input  wire logic [cetd_pkg::GEN_W-1:0]   cfg_data,
	output int                                mismatches,
	output int                                decodes_in_flight
);
	timeunit 1ns;
	timeprecision 1ps;

	import cetd_pkg::*;

	typedef struct packed {
		logic [WORD_W-1:0]  received;
		logic [WORD_W-1:0]  word;
		status_t            st;
		logic [SHIFT_W-1:0] shift;
		logic [SYN_W-1:0]   syn;
	} decode_t;

	logic [GEN_W-1:0]   gen_q   = GEN_RESET;
	logic [NLEN_W-1:0]  nlen_q  = NLEN_RESET;
	logic [KLEN_W-1:0]  klen_q  = KLEN_RESET;
	logic [LIMIT_W-1:0] limit_q = LIMIT_RESET;

	decode_t pending_decodes[$];

	initial begin
		mismatches = 0;
		decodes_in_flight = 0;
	end

	// Remainder of the low n bits of w modulo the generator, bit-serial long division.
	function automatic logic [63:0] gf2_remainder(input logic [63:0] w, input int n,
			input int p);
		for (int i = n; i > p; i--) begin
			if (w[i-1])
				w ^= {47'd0, gen_q} << (i - 1 - p);
		end
		return w & ((64'd1 << p) - 64'd1);
	endfunction

	function automatic logic [63:0] rotate_left(input logic [63:0] w, input int r,
			input int n, input logic [63:0] mask);
		if (r == 0)
			return w;
		return ((w << r) | (w >> (n - r))) & mask;
	endfunction

	function automatic decode_t decode_word(input logic [WORD_W-1:0] rx);
		decode_t     res;
		int          n;
		int          k;
		int          p;
		int          deg;
		logic [63:0] mask;
		logic [63:0] w;
		logic [63:0] syn;
		logic [63:0] rw;
		logic [63:0] s;
		n = int'(nlen_q);
		if (n > N_EFF_MAX)
			n = N_EFF_MAX;
		k = int'(klen_q);
		mask = (64'd1 << n) - 64'd1;
		w = {32'd0, rx} & mask;
		res.received = rx;
		res.word = w[WORD_W-1:0];
		res.st = ST_UNCORRECTABLE;
		res.shift = '0;
		res.syn = '0;
		if (n < 2 || k == 0 || k >= n)
			return res;
		p = n - k;
		deg = 0;
		for (int i = 0; i < GEN_W; i++) begin
			if (gen_q[i])
				deg = i;
		end
		if (p > PAR_LIM || deg != p)
			return res;
		syn = gf2_remainder(w, n, p);
		res.syn = syn[SYN_W-1:0];
		if (syn == 64'd0) begin
			res.st = ST_VALID;
			return res;
		end
		// Try every rotation until the syndrome is light enough to be the error itself.
		for (int r = 0; r < n; r++) begin
			rw = rotate_left(w, r, n, mask);
			s = gf2_remainder(rw, n, p);
			if ($countones(s) <= int'(limit_q)) begin
				res.word = rotate_left(rw ^ s, (n - r) % n, n, mask);
				res.st = ST_CORRECTED;
				res.shift = r[SHIFT_W-1:0];
				return res;
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		decode_t exp_d;
		if (!arst_n) begin
			gen_q = GEN_RESET;
			nlen_q = NLEN_RESET;
			klen_q = KLEN_RESET;
			limit_q = LIMIT_RESET;
			pending_decodes.delete();
			decodes_in_flight <= 0;
		end else begin
			// Results are retired before new items are predicted, so a result can never
			// be matched against an item accepted on the same edge.
			if (out_valid && !out_stall) begin
				if (pending_decodes.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result with no item waiting: word %h status %0d shift %0d syn %h",
							$realtime, corrected_word, status, shift_count, syndrome);
					mismatches++;
				end else begin
					exp_d = pending_decodes[0];
					pending_decodes.delete(0);
					if (corrected_word !== exp_d.word || status !== exp_d.st ||
							shift_count !== exp_d.shift || syndrome !== exp_d.syn) begin
						if (mismatches < 10)
							$display({"%0t: rx %h: expected word %h status %0d shift %0d syn %h,",
								" got word %h status %0d shift %0d syn %h"},
								$realtime, exp_d.received, exp_d.word, exp_d.st, exp_d.shift,
								exp_d.syn, corrected_word, status, shift_count, syndrome);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall)
				pending_decodes.insert(pending_decodes.size(), decode_word(received_word));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_GEN_POLY:      gen_q = cfg_data;
					CFG_CODE_LENGTH:   nlen_q = cfg_data[NLEN_W-1:0];
					CFG_INFO_LENGTH:   klen_q = cfg_data[KLEN_W-1:0];
					CFG_CORRECT_LIMIT: limit_q = cfg_data[LIMIT_W-1:0];
					default: ;
				endcase
			end
			decodes_in_flight <= pending_decodes.size();
		end
	end

endmodule

// File: tb/testbench.sv
// Top of the decoder testbench: clock, reset, register writes and received words,
// plus the final verdict. Depends on cetd_pkg, the decoder core and decode_checker.

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import cetd_pkg::*;

	// The tail wait leaves room for a stray result.
	localparam int TAIL_CYCLES  = 2 * N_EFF_MAX + 8;
	// Far beyond the slowest passing run.
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int ITEMS_VALID  = 60;
	localparam int ITEMS_BROKEN = 10;

	logic                  clk            = 1'b0;
	logic                  arst_n         = 1'b0;
	logic                  in_valid       = 1'b0;
	logic                  in_stall;
	logic [WORD_W-1:0]     received_word  = '0;
	logic                  out_valid;
	logic                  out_stall      = 1'b0;
	logic [WORD_W-1:0]     corrected_word;
	logic [1:0]            status;
	logic [SHIFT_W-1:0]    shift_count;
	logic [SYN_W-1:0]      syndrome;
	logic                  cfg_valid      = 1'b0;
	logic                  cfg_ready;
	logic [CIDX_W-1:0]     cfg_index      = CFG_GEN_POLY;
	logic [GEN_W-1:0]      cfg_data       = '0;

	int                    mismatches;
	int                    decodes_in_flight;
	int                    cycle_count    = 0;

	// Percent chance per cycle that the sender holds back or the receiver stalls.
	int                    sender_idle_pct    = 0;
	int                    receiver_stall_pct = 0;
	int                    phase_no           = 0;

	// The stimulus side's view of the code, used only to build codewords and errors.
	logic [GEN_W-1:0]      cur_gen = GEN_RESET;
	int                    cur_n   = 18;
	int                    cur_k   = 8;
	int                    cur_t   = 2;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	cyclic_error_trapping_decoder_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.received_word  (received_word),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.corrected_word (corrected_word),
		.status         (status),
		.shift_count    (shift_count),
		.syndrome       (syndrome),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	decode_checker u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.received_word     (received_word),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.corrected_word    (corrected_word),
		.status            (status),
		.shift_count       (shift_count),
		.syndrome          (syndrome),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.mismatches        (mismatches),
		.decodes_in_flight (decodes_in_flight)
	);

	// The receiver draws a fresh stall decision every cycle, so stalls land on every
	// phase of the decoder's work, including while the next item is already inside.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
	end

	// Watchdog: a hung handshake or a lost result ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[cyclic_error_trapping_decoder_core] ERROR");
			$finish;
		end
	end

	// Non-systematic encoding: a message polynomial times the generator is always a
	// multiple of g(x), so its syndrome is zero whatever the code length.
	function automatic logic [63:0] encode(input logic [63:0] msg);
		logic [63:0] prod;
		prod = '0;
		for (int i = 0; i < 32; i++) begin
			if (msg[i])
				prod ^= {47'd0, cur_gen} << i;
		end
		return prod;
	endfunction

	// Build one received word for the current code. Many words are codewords with a
	// light error burst inside a window as wide as the parity, which is exactly what
	// error trapping is meant to catch; the rest are clean codewords, scattered errors
	// that often defeat trapping, junk above the code length, and plain noise.
	function automatic logic [WORD_W-1:0] make_word();
		logic [63:0] mask;
		logic [63:0] cw;
		logic [63:0] err;
		int          p;
		int          nerr;
		int          start;
		int          pick;
		if (cur_n < 2 || cur_k < 1 || cur_k >= cur_n)
			return $urandom();
		mask = (64'd1 << cur_n) - 64'd1;
		p = cur_n - cur_k;
		cw = encode({$urandom(), $urandom()} & ((64'd1 << cur_k) - 64'd1)) & mask;
		err = '0;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			return cw[WORD_W-1:0];
		end else if (pick < 60) begin
			nerr = $urandom_range(1, (cur_t < 1) ? 1 : ((cur_t > p) ? p : cur_t));
			start = $urandom_range(0, cur_n - 1);
			repeat (nerr) err[(start + $urandom_range(0, p - 1)) % cur_n] = 1'b1;
		end else if (pick < 80) begin
			nerr = $urandom_range(1, cur_t + 2);
			repeat (nerr) err[$urandom_range(0, cur_n - 1)] = 1'b1;
		end else if (pick < 90) begin
			// Bits above the code length must be dropped by the decoder.
			err = {$urandom(), $urandom()} & ~mask;
			err[$urandom_range(0, cur_n - 1)] = 1'b1;
		end else begin
			return $urandom();
		end
		return WORD_W'(cw ^ err);
	endfunction

	// Present one item and hold it until the decoder takes it. Valid is left high on
	// return, so back-to-back items never lower and raise it in the same time step.
	task automatic send_word(input logic [WORD_W-1:0] w);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		received_word <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Stop sending and wait until every predicted result has been delivered. Every item
	// produces a result, so an empty prediction store means the decoder is idle.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (decodes_in_flight != 0)
			@(posedge clk);
	endtask

	// One register write. Narrow registers get random junk above their width about
	// half the time, since only the low bits of the write data are meant to count.
	task automatic write_reg(input cfg_index_t idx, input logic [GEN_W-1:0] value);
		logic [GEN_W-1:0] data;
		int               width;
		case (idx)
			CFG_GEN_POLY:    width = GEN_W;
			CFG_CODE_LENGTH: width = NLEN_W;
			default:         width = KLEN_W;
		endcase
		data = value;
		if (width < GEN_W && $urandom_range(0, 1) == 1)
			data |= GEN_W'($urandom()) << width;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// Reprogram the whole code while the decoder is idle, pick the next idling mode and
	// push a batch of random items through.
	task automatic run_setting(input logic [GEN_W-1:0] gen, input int nlen, input int klen,
			input int lim, input int count);
		drain();
		write_reg(CFG_GEN_POLY, gen);
		write_reg(CFG_CODE_LENGTH, GEN_W'(nlen));
		write_reg(CFG_INFO_LENGTH, GEN_W'(klen));
		write_reg(CFG_CORRECT_LIMIT, GEN_W'(lim));
		cfg_valid <= 1'b0;
		cur_gen = gen;
		cur_n = (nlen > N_EFF_MAX) ? N_EFF_MAX : nlen;
		cur_k = klen;
		cur_t = lim;
		// Rotate through: no idling, sender gaps, receiver stalls, then both at once.
		case (phase_no % 4)
			0: begin
				sender_idle_pct = 0;
				receiver_stall_pct = 0;
			end
			1: begin
				sender_idle_pct = 64;
				receiver_stall_pct = 0;
			end
			2: begin
				sender_idle_pct = 0;
				receiver_stall_pct = 64;
			end
			default: begin
				sender_idle_pct = 32;
				receiver_stall_pct = 32;
			end
		endcase
		phase_no++;
		repeat (count) send_word(make_word());
	endtask

	initial begin : stimulus
		int               p;
		int               nlen;
		logic [GEN_W-1:0] gen;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words against the reset code (degree-10 generator, n = 18, k = 8,
		// t = 2), which also proves the register reset values. They cover the all-zero
		// and all-one words, bits only above the code length, single errors at both ends,
		// an adjacent pair, a pair that wraps around the word, and a triple error that
		// exceeds the limit.
		send_word(32'h0000_0000);
		send_word(32'hFFFF_FFFF);
		send_word(32'h0003_FFFF);
		send_word(32'hFFFC_0000);
		send_word(32'h0000_0001);
		send_word(32'h0002_0000);
		send_word(WORD_W'(encode(64'hFF)));
		send_word(WORD_W'(encode(64'hFF) ^ 64'h1));
		send_word(WORD_W'(encode(64'hA5) ^ 64'h60));
		send_word(WORD_W'(encode(64'h5A) ^ 64'h2_0001));
		send_word(WORD_W'(encode(64'h5A) ^ 64'h7));
		send_word(32'hAAAA_AAAA);
		send_word(32'h5555_5555);

		// Known codes, then the corners: the widest parity with a limit that traps at
		// rotation zero, the smallest code, a zero limit that can never trap, and code
		// lengths beyond 32 that clamp to the word width.
		run_setting(GEN_RESET, 18, 8, 2, ITEMS_VALID);
		run_setting(17'h0000B, 7, 4, 1, ITEMS_VALID);
		run_setting(17'h001D1, 15, 7, 2, ITEMS_VALID);
		run_setting(17'h00C75, 23, 12, 3, ITEMS_VALID);
		run_setting(17'h18005, 32, 16, 16, ITEMS_VALID);
		run_setting(17'h00003, 2, 1, 1, ITEMS_VALID);
		run_setting(17'h0000B, 7, 4, 0, ITEMS_VALID);
		run_setting(17'h18005, 63, 16, 3, ITEMS_VALID);
		run_setting(17'h00003, 40, 31, 31, ITEMS_VALID);

		// Bad geometries: k not below n, a generator of the wrong degree, parity wider
		// than the syndrome, k of zero, a code shorter than two bits, a zero generator.
		run_setting(GEN_RESET, 8, 8, 2, ITEMS_BROKEN);
		run_setting(17'h001D1, 18, 8, 2, ITEMS_BROKEN);
		run_setting(17'h18005, 32, 8, 3, ITEMS_BROKEN);
		run_setting(17'h00003, 5, 0, 1, ITEMS_BROKEN);
		run_setting(17'h00003, 1, 1, 1, ITEMS_BROKEN);
		run_setting(17'h1FFFF, 20, 8, 2, ITEMS_BROKEN);
		run_setting(17'h00000, 10, 5, 2, ITEMS_BROKEN);

		// Random codes with a generator of the right degree and a small limit.
		repeat (4) begin
			p = $urandom_range(1, PAR_LIM);
			nlen = $urandom_range(p + 1, N_EFF_MAX);
			gen = (GEN_W'(1) << p) | (GEN_W'($urandom()) & ((GEN_W'(1) << p) - GEN_W'(1)));
			if ($urandom_range(0, 3) != 0)
				gen[0] = 1'b1;
			run_setting(gen, nlen, nlen - p, $urandom_range(0, 4), ITEMS_VALID);
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[cyclic_error_trapping_decoder_core] OK");
		else
			$display("[cyclic_error_trapping_decoder_core] ERROR");
		$finish;
	end

endmodule

// File: cyclic_error_trapping_decoder_core.f
design/cetd_pkg.sv
design/cetd_ctrl.sv
design/cetd_datapath.sv
design/cyclic_error_trapping_decoder_core.sv
tb/decode_checker.sv
tb/testbench.sv
